// ===== rtl/core/gtmq_pkg.sv =====
// gtmq_pkg: shared types and constants for the gamepad trigger mode qualifier.
// No dependencies; imported by every module under rtl/core.
package gtmq_pkg;

  localparam int TICK_W = 16;
  localparam int BTN_W = 14;
  localparam int MODE_W = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PHASE_W = 2;

  // register indexes on the config port
  localparam logic [CFG_INDEX_W-1:0] CFG_TAP_DURATION = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MENU_DURATION = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALLOW_DOUBLE_TAP = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALLOW_PRIORITY = 2'd3;

  localparam logic [TICK_W-1:0] TAP_DURATION_RST = 16'd200;
  localparam logic [TICK_W-1:0] MENU_DURATION_RST = 16'd1000;

  // macro modes
  localparam logic [MODE_W-1:0] MODE_NONE = 4'd0;
  localparam logic [MODE_W-1:0] MODE_LT = 4'd1;
  localparam logic [MODE_W-1:0] MODE_RT = 4'd2;
  localparam logic [MODE_W-1:0] MODE_BOTH_LT_FIRST = 4'd3;
  localparam logic [MODE_W-1:0] MODE_BOTH_RT_FIRST = 4'd4;
  localparam logic [MODE_W-1:0] MODE_LT_DOUBLE = 4'd5;
  localparam logic [MODE_W-1:0] MODE_RT_DOUBLE = 4'd6;
  localparam logic [MODE_W-1:0] MODE_LS = 4'd7;
  localparam logic [MODE_W-1:0] MODE_RS = 4'd8;

  // hold-combo phases
  localparam logic [PHASE_W-1:0] PHASE_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_WAIT = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_DONE = 2'd2;

  typedef struct packed {
    logic [TICK_W-1:0] tap_duration;
    logic [TICK_W-1:0] menu_duration;
    logic              allow_double_tap;
    logic              allow_priority;
  } cfg_t;

  typedef struct packed {
    logic              left_trigger;
    logic              right_trigger;
    logic              left_shoulder;
    logic              right_shoulder;
    logic [BTN_W-1:0]  button_levels;
    logic              window_focused;
    logic [TICK_W-1:0] elapsed_ticks;
  } sample_t;

  typedef struct packed {
    logic [MODE_W-1:0] macro_mode;
    logic              mode_valid;
    logic              menu_combo_fired;
    logic [BTN_W-1:0]  pressed_mask;
  } result_t;

endpackage

// ===== rtl/core/gamepad_trigger_mode_qualifier.sv =====
// Gamepad trigger mode qualifier, top level. Depends on gtmq_pkg, gtmq_cfg, gtmq_core.
// Path: a request is held in the input register, then in the result register, where
// out_valid rises for it; out_stall can hold it in either register.
// Throughput: one request per cycle while out_stall is low, bounded by the
// single state update in gtmq_core. Reset (rst, synchronous, active high)
// empties both stages, restores the config defaults and clears all sample state.
module gamepad_trigger_mode_qualifier #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               left_trigger,
  input  logic                               right_trigger,
  input  logic                               left_shoulder,
  input  logic                               right_shoulder,
  input  logic [gtmq_pkg::BTN_W-1:0]         button_levels,
  input  logic                               window_focused,
  input  logic [gtmq_pkg::TICK_W-1:0]        elapsed_ticks,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [gtmq_pkg::MODE_W-1:0]        macro_mode,
  output logic                               mode_valid,
  output logic                               menu_combo_fired,
  output logic [gtmq_pkg::BTN_W-1:0]         pressed_mask,
  // configuration write port
  input  logic                               cfg_write_en,
  input  logic [gtmq_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [gtmq_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import gtmq_pkg::*;

  cfg_t    cfg;
  sample_t sample;
  result_t step_result;
  result_t result;
  logic    s1_valid;
  logic    out_free;
  logic    step_en;
  logic    in_take;

  // result register can take a new value when empty or being drained
  assign out_free = !out_valid || !out_stall;
  // the staged request moves on and updates state in the same edge
  assign step_en = s1_valid && out_free;
  // input register refills whenever it empties or moves on this cycle
  assign in_stall = s1_valid && !out_free;
  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (step_en) begin
      s1_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      sample.left_trigger <= left_trigger;
      sample.right_trigger <= right_trigger;
      sample.left_shoulder <= left_shoulder;
      sample.right_shoulder <= right_shoulder;
      sample.button_levels <= button_levels;
      sample.window_focused <= window_focused;
      sample.elapsed_ticks <= elapsed_ticks;
    end
  end

  gtmq_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .write_en (cfg_write_en),
    .index    (cfg_index),
    .data     (cfg_data),
    .cfg      (cfg)
  );

  gtmq_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step_en (step_en),
    .sample  (sample),
    .result  (step_result)
  );

  // result register; holds while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step_en;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      result <= step_result;
    end
  end

  assign macro_mode = result.macro_mode;
  assign mode_valid = result.mode_valid;
  assign menu_combo_fired = result.menu_combo_fired;
  assign pressed_mask = result.pressed_mask;

endmodule

// ===== rtl/core/gtmq_cfg.sv =====
// gtmq_cfg: configuration register file, written through a plain write port.
// Depends on gtmq_pkg.
module gtmq_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                write_en,
  input  logic [gtmq_pkg::CFG_INDEX_W-1:0]    index,
  input  logic [gtmq_pkg::CFG_DATA_W-1:0]     data,
  output gtmq_pkg::cfg_t                      cfg
);
  import gtmq_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.tap_duration <= TAP_DURATION_RST;
      regs.menu_duration <= MENU_DURATION_RST;
      regs.allow_double_tap <= 1'b1;
      regs.allow_priority <= 1'b1;
    end else if (write_en) begin
      case (index)
        CFG_TAP_DURATION: begin
          regs.tap_duration <= data[TICK_W-1:0];
        end
        CFG_MENU_DURATION: begin
          regs.menu_duration <= data[TICK_W-1:0];
        end
        CFG_ALLOW_DOUBLE_TAP: begin
          regs.allow_double_tap <= data[0];
        end
        CFG_ALLOW_PRIORITY: begin
          regs.allow_priority <= data[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== rtl/core/gtmq_core.sv =====
// gtmq_core: per-sample state (previous levels, tap timers, combo timer) and
// the single-pass mode / combo / edge logic. Depends on gtmq_pkg.
module gtmq_core #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  gtmq_pkg::cfg_t    cfg,
  input  logic              step_en,
  input  gtmq_pkg::sample_t sample,
  output gtmq_pkg::result_t result
);
  import gtmq_pkg::*;

  localparam int WW = (TIMER_WIDTH > TICK_W) ? TIMER_WIDTH : TICK_W;
  localparam int SW = WW + 1;
  localparam logic [WW-1:0] TMAX_W = WW'({TIMER_WIDTH{1'b1}});
  localparam logic [SW-1:0] TMAX_S = SW'({TIMER_WIDTH{1'b1}});

  logic [BTN_W+3:0]       previous_levels, previous_levels_next;
  logic                   last_focused, last_focused_next;
  logic                   right_came_first, right_came_first_next;
  logic                   left_tap_flag, left_tap_flag_next;
  logic                   right_tap_flag, right_tap_flag_next;
  logic [TIMER_WIDTH-1:0] left_tap_remaining, left_tap_remaining_next;
  logic [TIMER_WIDTH-1:0] right_tap_remaining, right_tap_remaining_next;
  logic [PHASE_W-1:0]     combo_phase, combo_phase_next;
  logic [TIMER_WIDTH-1:0] combo_age, combo_age_next;

  logic [WW-1:0]          dt_w, lrem_w, rrem_w, tap_w;
  logic [TIMER_WIDTH-1:0] lrem_dec, rrem_dec, tap_clamped;
  logic [SW-1:0]          age_sum;
  logic [BTN_W+3:0]       levels;
  logic                   lt, rt, ls, rs, fresh, all_held, regained;

  assign lt = sample.left_trigger;
  assign rt = sample.right_trigger;
  assign ls = sample.left_shoulder;
  assign rs = sample.right_shoulder;
  assign levels = {rs, ls, rt, lt, sample.button_levels};
  assign all_held = lt & rt & ls & rs;
  assign regained = !last_focused && sample.window_focused;
  // fresh press: neither trigger held in stored sample
  assign fresh = !previous_levels[BTN_W] && !previous_levels[BTN_W+1];

  assign dt_w = WW'(sample.elapsed_ticks);
  assign lrem_w = WW'(left_tap_remaining);
  assign rrem_w = WW'(right_tap_remaining);
  assign tap_w = WW'(cfg.tap_duration);

  // countdowns stop at zero
  assign lrem_dec = (lrem_w > dt_w) ? TIMER_WIDTH'(lrem_w - dt_w) : '0;
  assign rrem_dec = (rrem_w > dt_w) ? TIMER_WIDTH'(rrem_w - dt_w) : '0;
  assign tap_clamped = (tap_w > TMAX_W) ? {TIMER_WIDTH{1'b1}} : tap_w[TIMER_WIDTH-1:0];
  assign age_sum = (combo_phase == PHASE_WAIT) ?
                   (SW'(combo_age) + SW'(sample.elapsed_ticks)) : '0;

  always_comb begin
    previous_levels_next = levels;
    last_focused_next = sample.window_focused;
    right_came_first_next = right_came_first;
    left_tap_flag_next = left_tap_flag;
    right_tap_flag_next = right_tap_flag;
    left_tap_remaining_next = lrem_dec;
    right_tap_remaining_next = rrem_dec;
    combo_phase_next = combo_phase;
    combo_age_next = combo_age;
    result.macro_mode = MODE_NONE;
    result.mode_valid = 1'b0;
    result.menu_combo_fired = 1'b0;
    result.pressed_mask = '0;

    if (combo_phase == PHASE_WAIT) begin
      combo_age_next = (age_sum > TMAX_S) ? {TIMER_WIDTH{1'b1}} : age_sum[TIMER_WIDTH-1:0];
    end

    if (!regained) begin
      // trigger tap tracking
      if (lt) begin
        if (fresh) begin
          if (lrem_dec != '0) begin
            left_tap_flag_next = 1'b1;
          end
          left_tap_remaining_next = tap_clamped;
          right_came_first_next = 1'b0;
        end
      end else begin
        left_tap_flag_next = 1'b0;
      end
      if (rt) begin
        if (fresh) begin
          if (rrem_dec != '0) begin
            right_tap_flag_next = 1'b1;
          end
          right_tap_remaining_next = tap_clamped;
          right_came_first_next = 1'b1;
        end
      end else begin
        right_tap_flag_next = 1'b0;
      end

      if (lt && rt) begin
        left_tap_flag_next = 1'b0;
        right_tap_flag_next = 1'b0;
        left_tap_remaining_next = '0;
        right_tap_remaining_next = '0;
        result.macro_mode = (cfg.allow_priority && right_came_first_next) ?
                            MODE_BOTH_RT_FIRST : MODE_BOTH_LT_FIRST;
      end else if (lt) begin
        result.macro_mode = (cfg.allow_double_tap && left_tap_flag_next) ?
                            MODE_LT_DOUBLE : MODE_LT;
      end else if (rt) begin
        result.macro_mode = (cfg.allow_double_tap && right_tap_flag_next) ?
                            MODE_RT_DOUBLE : MODE_RT;
      end else if (ls) begin
        result.macro_mode = MODE_LS;
      end else if (rs) begin
        result.macro_mode = MODE_RS;
      end

      // hold combo
      if (all_held) begin
        if (combo_phase == PHASE_IDLE) begin
          combo_phase_next = PHASE_WAIT;
          combo_age_next = '0;
        end else if (combo_phase == PHASE_WAIT &&
                     age_sum > SW'(cfg.menu_duration)) begin
          result.menu_combo_fired = 1'b1;
          combo_phase_next = PHASE_DONE;
        end
      end else begin
        combo_phase_next = PHASE_IDLE;
        combo_age_next = '0;
      end

      result.mode_valid = 1'b1;
      result.pressed_mask = sample.button_levels & ~previous_levels[BTN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_levels <= '0;
      last_focused <= 1'b1;
      right_came_first <= 1'b0;
      left_tap_flag <= 1'b0;
      right_tap_flag <= 1'b0;
      left_tap_remaining <= '0;
      right_tap_remaining <= '0;
      combo_phase <= PHASE_IDLE;
      combo_age <= '0;
    end else if (step_en) begin
      previous_levels <= previous_levels_next;
      last_focused <= last_focused_next;
      right_came_first <= right_came_first_next;
      left_tap_flag <= left_tap_flag_next;
      right_tap_flag <= right_tap_flag_next;
      left_tap_remaining <= left_tap_remaining_next;
      right_tap_remaining <= right_tap_remaining_next;
      combo_phase <= combo_phase_next;
      combo_age <= combo_age_next;
    end
  end

endmodule
